/* rtl/swc_pkg.sv */
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, constants and the dictionary for the stopword counter.
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

    // field widths fixed by the interface
    localparam int BYTE_W       = 8;
    localparam int WORD_INDEX_W = 5;
    localparam int POS_W        = 48;
    localparam int OUT_CNT_W    = 48;
    localparam int DICT_WORD_W  = 64;
    localparam int DICT_LEN_W   = 4;

    // dictionary size
    localparam int DICT_SIZE = 20;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_BASE_OFFSET = 1'b0;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    // saturation limit of positions and reported counts
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // control part of a request travelling through the chain
    typedef struct packed {
        logic                    valid;
        logic                    hit;
        logic [WORD_INDEX_W-1:0] idx;
    } t_ctl;

    // one dictionary entry, first byte highest, right aligned
    typedef struct packed {
        logic [DICT_LEN_W-1:0]  len;
        logic [DICT_WORD_W-1:0] word;
    } t_dict;

    // dictionary lookup, entries past the table have length zero and never match
    function automatic t_dict dict_entry(input int idx);
        t_dict d;
        d.len  = '0;
        d.word = '0;
        case (idx)
            0:  begin d.len = 4'd3; d.word = 64'h746865;   end
            1:  begin d.len = 4'd2; d.word = 64'h6265;     end
            2:  begin d.len = 4'd2; d.word = 64'h746f;     end
            3:  begin d.len = 4'd2; d.word = 64'h6f66;     end
            4:  begin d.len = 4'd3; d.word = 64'h616e64;   end
            5:  begin d.len = 4'd1; d.word = 64'h61;       end
            6:  begin d.len = 4'd2; d.word = 64'h696e;     end
            7:  begin d.len = 4'd4; d.word = 64'h74686174; end
            8:  begin d.len = 4'd4; d.word = 64'h68617665; end
            9:  begin d.len = 4'd1; d.word = 64'h69;       end
            10: begin d.len = 4'd2; d.word = 64'h6974;     end
            11: begin d.len = 4'd3; d.word = 64'h666f72;   end
            12: begin d.len = 4'd3; d.word = 64'h6e6f74;   end
            13: begin d.len = 4'd2; d.word = 64'h6f6e;     end
            14: begin d.len = 4'd4; d.word = 64'h77697468; end
            15: begin d.len = 4'd2; d.word = 64'h6865;     end
            16: begin d.len = 4'd2; d.word = 64'h6173;     end
            17: begin d.len = 4'd3; d.word = 64'h796f75;   end
            18: begin d.len = 4'd2; d.word = 64'h646f;     end
            19: begin d.len = 4'd2; d.word = 64'h6174;     end
            default: begin d.len = '0; d.word = '0; end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/swc_front.sv */
// ----------------------------------------------------------------------------
// swc_front
// Word assembly: case folding, word buffer, byte position and start position.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_front #(
    parameter int MAX_WORD_LEN = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_fire,
    input  wire logic [swc_pkg::BYTE_W-1:0]            i_text_byte,
    input  wire logic [swc_pkg::POS_W-1:0]             i_base_offset,
    output logic                                       o_tok_valid,
    output logic [swc_pkg::BYTE_W*MAX_WORD_LEN-1:0]    o_tok_word,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0]          o_tok_len,
    output logic [swc_pkg::POS_W-1:0]                  o_tok_start
);

    localparam int WORD_W = swc_pkg::BYTE_W * MAX_WORD_LEN;
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);

    logic [WORD_W-1:0]         r_word, n_word;
    logic [LEN_W-1:0]          r_len, n_len;
    logic                      r_too_long, n_too_long;
    logic [swc_pkg::POS_W-1:0] r_pos, n_pos;

    logic                      is_space;
    logic [swc_pkg::BYTE_W-1:0] folded;
    logic [swc_pkg::POS_W:0]   sum;
    logic [swc_pkg::POS_W:0]   diff;

    // byte classification and case folding
    always_comb begin
        is_space = (i_text_byte == swc_pkg::CHAR_SPACE);
        if (i_text_byte >= swc_pkg::CHAR_UPPER_A && i_text_byte <= swc_pkg::CHAR_UPPER_Z) begin
            folded = i_text_byte + swc_pkg::CASE_OFFSET;
        end else begin
            folded = i_text_byte;
        end
    end

    // request toward the chain when a space closes a word that can still match
    always_comb begin
        o_tok_valid = is_space && (r_len != '0) && !r_too_long;
        o_tok_word  = r_word;
        o_tok_len   = r_len;
        sum  = {1'b0, i_base_offset} + {1'b0, r_pos};
        diff = sum - (swc_pkg::POS_W+1)'(r_len);
        if (sum < (swc_pkg::POS_W+1)'(r_len)) begin
            o_tok_start = '0;
        end else if (diff[swc_pkg::POS_W]) begin
            o_tok_start = swc_pkg::POS_MAX;
        end else begin
            o_tok_start = diff[swc_pkg::POS_W-1:0];
        end
    end

    // next word state
    always_comb begin
        n_word     = r_word;
        n_len      = r_len;
        n_too_long = r_too_long;
        n_pos      = r_pos;
        if (i_fire) begin
            if (is_space) begin
                n_word     = '0;
                n_len      = '0;
                n_too_long = 1'b0;
            end else if (r_len < LEN_W'(MAX_WORD_LEN)) begin
                n_word = (r_word << swc_pkg::BYTE_W) | WORD_W'(folded);
                n_len  = LEN_W'(r_len + 1'b1);
            end else begin
                n_too_long = 1'b1;
            end
            if (r_pos != swc_pkg::POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // word state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_len      <= '0;
            r_too_long <= 1'b0;
            r_pos      <= '0;
        end else begin
            r_word     <= n_word;
            r_len      <= n_len;
            r_too_long <= n_too_long;
            r_pos      <= n_pos;
        end
    end

endmodule

`default_nettype wire

/* rtl/swc_cell.sv */
// ----------------------------------------------------------------------------
// swc_cell
// One dictionary word: compares the passing request and keeps its counter.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_cell #(
    parameter int CELL_IDX     = 0,
    parameter int MAX_WORD_LEN = 4,
    parameter int COUNT_WIDTH  = 48
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire swc_pkg::t_ctl                         i_ctl,
    input  wire logic [swc_pkg::BYTE_W*MAX_WORD_LEN-1:0] i_word,
    input  wire logic [$clog2(MAX_WORD_LEN+1)-1:0]     i_len,
    input  wire logic [swc_pkg::POS_W-1:0]             i_start,
    input  wire logic [swc_pkg::OUT_CNT_W-1:0]         i_cnt,
    input  wire logic                                  i_down_take,
    output logic                                       o_take,
    output swc_pkg::t_ctl                              o_ctl,
    output logic [swc_pkg::BYTE_W*MAX_WORD_LEN-1:0]    o_word,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0]          o_len,
    output logic [swc_pkg::POS_W-1:0]                  o_start,
    output logic [swc_pkg::OUT_CNT_W-1:0]              o_cnt
);

    localparam int WORD_W = swc_pkg::BYTE_W * MAX_WORD_LEN;
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam swc_pkg::t_dict DICT = swc_pkg::dict_entry(CELL_IDX);

    swc_pkg::t_ctl                 r_ctl;
    logic [WORD_W-1:0]             r_word;
    logic [LEN_W-1:0]              r_len;
    logic [swc_pkg::POS_W-1:0]     r_start;
    logic [swc_pkg::OUT_CNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0]        r_count, n_count;
    swc_pkg::t_ctl                 n_ctl;

    logic                          match;
    logic [63:0]                   count_ext;

    // slot is free when empty or when the next stage takes its content
    assign o_take = !r_ctl.valid || i_down_take;

    // compare against this cell's dictionary word
    always_comb begin
        match = i_ctl.valid && !i_ctl.hit
             && (swc_pkg::DICT_LEN_W'(i_len) == DICT.len)
             && (swc_pkg::DICT_WORD_W'(i_word) == DICT.word);
    end

    // counter update and reported count
    always_comb begin
        n_ctl   = i_ctl;
        n_cnt   = i_cnt;
        n_count = r_count;
        if (r_count != {COUNT_WIDTH{1'b1}}) begin
            n_count = r_count + 1'b1;
        end
        count_ext = 64'(n_count);
        if (match) begin
            n_ctl.hit = 1'b1;
            n_ctl.idx = swc_pkg::WORD_INDEX_W'(CELL_IDX);
            if (count_ext > 64'(swc_pkg::POS_MAX)) begin
                n_cnt = swc_pkg::OUT_CNT_W'(swc_pkg::POS_MAX);
            end else begin
                n_cnt = count_ext[swc_pkg::OUT_CNT_W-1:0];
            end
        end
    end

    // control and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_count <= '0;
        end else begin
            if (o_take) begin
                r_ctl <= n_ctl;
            end
            if (o_take && match) begin
                r_count <= n_count;
            end
        end
    end

    // request payload registers
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word  <= i_word;
            r_len   <= i_len;
            r_start <= i_start;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_word  = r_word;
    assign o_len   = r_len;
    assign o_start = r_start;
    assign o_cnt   = r_cnt;

endmodule

`default_nettype wire

/* rtl/stopword_counter_indexer_top.sv */
// A request passes through the NUM_WORDS cell registers of the chain before
// its result leaves. Throughput: one byte per cycle unless a space waits; the
// request chain moves one cell a cycle and closes gaps, so a stalled result
// blocks spaces only once the chain is full. Bytes other than spaces are taken
// in every cycle. Reset (synchronous, active low) clears all counters, the
// word buffer, the byte position, base_offset and the chain.
// ----------------------------------------------------------------------------
// stopword_counter_indexer_top
// Counts dictionary words in a byte stream and reports index, start and count.
// ----------------------------------------------------------------------------
`default_nettype none

module stopword_counter_indexer_top #(
    parameter int NUM_WORDS    = 20,
    parameter int MAX_WORD_LEN = 4,
    parameter int COUNT_WIDTH  = 48
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // text input
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [swc_pkg::BYTE_W-1:0]           i_text_byte,
    // results
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [swc_pkg::WORD_INDEX_W-1:0]          o_word_index,
    output logic [swc_pkg::POS_W-1:0]                 o_start_position,
    output logic [swc_pkg::OUT_CNT_W-1:0]             o_new_count,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [swc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [swc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [swc_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                      pready
);

    localparam int WORD_W = swc_pkg::BYTE_W * MAX_WORD_LEN;
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);

    logic [swc_pkg::POS_W-1:0] r_base_offset;

    logic                      in_fire;
    logic                      tok_valid;
    logic [WORD_W-1:0]         tok_word;
    logic [LEN_W-1:0]          tok_len;
    logic [swc_pkg::POS_W-1:0] tok_start;

    swc_pkg::t_ctl                 ctl   [NUM_WORDS+1];
    logic [WORD_W-1:0]             word  [NUM_WORDS+1];
    logic [LEN_W-1:0]              len   [NUM_WORDS+1];
    logic [swc_pkg::POS_W-1:0]     start [NUM_WORDS+1];
    logic [swc_pkg::OUT_CNT_W-1:0] cnt   [NUM_WORDS+1];
    logic                          take  [NUM_WORDS+1];

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[3] == swc_pkg::REG_BASE_OFFSET) begin
            r_base_offset <= pwdata[swc_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        if (paddr[3] == swc_pkg::REG_BASE_OFFSET) begin
            prdata = swc_pkg::APB_DATA_W'(r_base_offset);
        end else begin
            prdata = '0;
        end
    end

    // input handshake: only a space carrying a request waits on the chain
    assign o_ready = !tok_valid || take[0];
    assign in_fire = i_valid && o_ready;

    swc_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_text_byte   (i_text_byte),
        .i_base_offset (r_base_offset),
        .o_tok_valid   (tok_valid),
        .o_tok_word    (tok_word),
        .o_tok_len     (tok_len),
        .o_tok_start   (tok_start)
    );

    // request entering the first cell
    always_comb begin
        ctl[0].valid = in_fire && tok_valid;
        ctl[0].hit   = 1'b0;
        ctl[0].idx   = '0;
        word[0]      = tok_word;
        len[0]       = tok_len;
        start[0]     = tok_start;
        cnt[0]       = '0;
    end

    // last cell drops requests that matched nothing
    assign take[NUM_WORDS] = i_ready || !ctl[NUM_WORDS].hit;

    // chain of word cells
    for (genvar g = 0; g < NUM_WORDS; g++) begin : g_cell
        swc_cell #(
            .CELL_IDX     (g),
            .MAX_WORD_LEN (MAX_WORD_LEN),
            .COUNT_WIDTH  (COUNT_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[g]),
            .i_word      (word[g]),
            .i_len       (len[g]),
            .i_start     (start[g]),
            .i_cnt       (cnt[g]),
            .i_down_take (take[g+1]),
            .o_take      (take[g]),
            .o_ctl       (ctl[g+1]),
            .o_word      (word[g+1]),
            .o_len       (len[g+1]),
            .o_start     (start[g+1]),
            .o_cnt       (cnt[g+1])
        );
    end

    // result from the last cell
    assign o_valid          = ctl[NUM_WORDS].valid && ctl[NUM_WORDS].hit;
    assign o_word_index     = ctl[NUM_WORDS].idx;
    assign o_start_position = start[NUM_WORDS];
    assign o_new_count      = cnt[NUM_WORDS];

endmodule

`default_nettype wire

/* rtl/swc_checker.sv */
// ----------------------------------------------------------------------------
// swc_checker
// Port-level checks of the stopword counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_ready,
    input wire logic [swc_pkg::BYTE_W-1:0]           i_text_byte,
    input wire logic                                 o_valid,
    input wire logic                                 i_ready,
    input wire logic [swc_pkg::WORD_INDEX_W-1:0]     o_word_index,
    input wire logic [swc_pkg::POS_W-1:0]            o_start_position,
    input wire logic [swc_pkg::OUT_CNT_W-1:0]        o_new_count
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word_index)
            && $stable(o_start_position) && $stable(o_new_count))
        else $error("stalled result changed");

    // a reported count includes the word itself
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_new_count != '0)
        else $error("result count is zero");

    // only dictionary indexes are reported
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word_index < swc_pkg::WORD_INDEX_W'(swc_pkg::DICT_SIZE))
        else $error("result index outside dictionary");

    // bytes other than space never wait, even with a stalled result
    a_nonspace_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_text_byte != swc_pkg::CHAR_SPACE |-> o_ready)
        else $error("non-space byte stalled");

endmodule

bind stopword_counter_indexer_top swc_checker u_swc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_text_byte      (i_text_byte),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_word_index     (o_word_index),
    .o_start_position (o_start_position),
    .o_new_count      (o_new_count)
);

`default_nettype wire
